>>> sv/brf_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Base relocation fixup package
// Shared types, codes and constants for the relocation fixup block.
// -----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned TYPE_W     = ENTRY_W - OFFSET_W;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [OFFSET_W-1:0] OFFSET_MASK = 12'hFFF;
  localparam logic [WORD_W-1:0]   ROUND_HALF  = 32'h0000_8000;
  localparam logic [HALF_W-1:0]   HALF_MASK   = 16'hFFFF;

  // Byte counts used by the bounds check.
  localparam logic [WORD_W:0] NEED_HALF = 33'd2;
  localparam logic [WORD_W:0] NEED_WORD = 33'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_DELTA = 2'd0,
    REG_IMAGE_SIZE = 2'd1
  } brf_reg_idx_t;

  typedef enum logic [TYPE_W-1:0] {
    ET_PAD      = 4'd0,
    ET_HIGH     = 4'd1,
    ET_LOW      = 4'd2,
    ET_WORD     = 4'd3,
    ET_HIGH_ADJ = 4'd4
  } brf_entry_type_t;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_HALF = 2'd1,
    WK_WORD = 2'd2
  } brf_kind_t;

  typedef enum logic [2:0] {
    ST_APPLIED   = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_OUT_BOUND = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_ADJ_PEND  = 3'd4,
    ST_ADJ_DROP  = 3'd5
  } brf_status_t;

  typedef struct packed {
    logic [WORD_W-1:0] load_delta;
    logic [WORD_W-1:0] image_size;
  } brf_cfg_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [WORD_W-1:0]  page_rva;
    logic [WORD_W-1:0]  target_value;
    logic               last_in_block;
  } brf_item_t;

  typedef struct packed {
    brf_kind_t         write_kind;
    logic [WORD_W-1:0] target_addr;
    logic [WORD_W-1:0] new_value;
    brf_status_t       status;
  } brf_result_t;

endpackage

>>> sv/brf_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Relocation fixup channel interfaces
// Valid/ready channels for entries, results and configuration writes.
// -----------------------------------------------------------------------------
interface brf_in_if;
  import brf_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry;
  logic [WORD_W-1:0]  page_rva;
  logic [WORD_W-1:0]  target_value;
  logic               last_in_block;

  modport source (output valid, entry, page_rva, target_value, last_in_block,
                  input ready);
  modport sink   (input valid, entry, page_rva, target_value, last_in_block,
                  output ready);
endinterface

interface brf_out_if;
  import brf_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        write_kind;
  logic [WORD_W-1:0] target_addr;
  logic [WORD_W-1:0] new_value;
  logic [2:0]        status;

  modport source (output valid, write_kind, target_addr, new_value, status,
                  input ready);
  modport sink   (input valid, write_kind, target_addr, new_value, status,
                  output ready);
endinterface

interface brf_cfg_if;
  import brf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/brf_cfg_regs.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Relocation fixup configuration registers
// Holds the relocation delta and the image size bound.
// -----------------------------------------------------------------------------
module brf_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  brf_cfg_if.sink            cfg_chan,
  output brf_pkg::brf_cfg_t  cfg
);
  import brf_pkg::*;

  brf_cfg_t cfg_r;
  brf_cfg_t cfg_nxt;
  logic     wr_en;

  assign cfg_chan.ready = 1'b1;
  assign wr_en          = cfg_chan.valid && cfg_chan.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_chan.index)
        REG_LOAD_DELTA: cfg_nxt.load_delta = cfg_chan.data;
        REG_IMAGE_SIZE: cfg_nxt.image_size = cfg_chan.data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

>>> sv/brf_fixup.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Relocation fixup datapath
// Decodes one entry, patches the target and keeps the pending high-adjust.
// -----------------------------------------------------------------------------
module brf_fixup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  brf_pkg::brf_cfg_t    cfg,
  input  brf_pkg::brf_item_t   item,
  input  logic                 advance,
  output brf_pkg::brf_result_t result
);
  import brf_pkg::*;

  logic              adj_pend_r, adj_pend_nxt;
  logic [WORD_W-1:0] adj_addr_r, adj_addr_nxt;
  logic [HALF_W-1:0] adj_high_r, adj_high_nxt;
  logic              adj_inb_r, adj_inb_nxt;

  brf_entry_type_t   ent_type;
  logic [WORD_W-1:0] addr;
  logic              fits_half;
  logic              fits_word;
  logic              delta_zero;
  logic [WORD_W-1:0] adj_sum;
  logic [WORD_W-1:0] adj_round;
  logic [HALF_W-1:0] half_hi_sum;
  logic [HALF_W-1:0] half_lo_sum;

  assign ent_type   = brf_entry_type_t'(item.entry[ENTRY_W-1:OFFSET_W]);
  assign addr       = item.page_rva
                    + {{(WORD_W-OFFSET_W){1'b0}}, item.entry[OFFSET_W-1:0] & OFFSET_MASK};
  assign fits_half  = ({1'b0, addr} + NEED_HALF) <= {1'b0, cfg.image_size};
  assign fits_word  = ({1'b0, addr} + NEED_WORD) <= {1'b0, cfg.image_size};
  assign delta_zero = (cfg.load_delta == '0);

  // The held high half and the addend entry form a full word before the delta is added.
  assign adj_sum     = {adj_high_r, {HALF_W{1'b0}}} + {{(WORD_W-ENTRY_W){1'b0}}, item.entry}
                     + cfg.load_delta;
  assign adj_round   = adj_sum + ROUND_HALF;
  assign half_hi_sum = (item.target_value[HALF_W-1:0] + cfg.load_delta[WORD_W-1:HALF_W])
                     & HALF_MASK;
  assign half_lo_sum = (item.target_value[HALF_W-1:0] + cfg.load_delta[HALF_W-1:0])
                     & HALF_MASK;

  always_comb begin
    result.write_kind  = WK_NONE;
    result.target_addr = addr;
    result.new_value   = '0;
    result.status      = ST_SKIPPED;
    if (adj_pend_r) begin
      result.target_addr = adj_addr_r;
      if (delta_zero) begin
        result.status = ST_SKIPPED;
      end else if (!adj_inb_r) begin
        result.status = ST_OUT_BOUND;
      end else begin
        result.write_kind = WK_HALF;
        result.new_value  = {{HALF_W{1'b0}}, adj_round[WORD_W-1:HALF_W]};
        result.status     = ST_APPLIED;
      end
    end else if (!delta_zero) begin
      unique case (ent_type)
        ET_PAD: result.status = ST_SKIPPED;
        ET_HIGH: begin
          if (fits_half) begin
            result.write_kind = WK_HALF;
            result.new_value  = {{HALF_W{1'b0}}, half_hi_sum};
            result.status     = ST_APPLIED;
          end else begin
            result.status = ST_OUT_BOUND;
          end
        end
        ET_LOW: begin
          if (fits_half) begin
            result.write_kind = WK_HALF;
            result.new_value  = {{HALF_W{1'b0}}, half_lo_sum};
            result.status     = ST_APPLIED;
          end else begin
            result.status = ST_OUT_BOUND;
          end
        end
        ET_WORD: begin
          if (fits_word) begin
            result.write_kind = WK_WORD;
            result.new_value  = item.target_value + cfg.load_delta;
            result.status     = ST_APPLIED;
          end else begin
            result.status = ST_OUT_BOUND;
          end
        end
        ET_HIGH_ADJ: result.status = item.last_in_block ? ST_ADJ_DROP : ST_ADJ_PEND;
        default:     result.status = ST_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    adj_pend_nxt = adj_pend_r;
    adj_addr_nxt = adj_addr_r;
    adj_high_nxt = adj_high_r;
    adj_inb_nxt  = adj_inb_r;
    if (advance) begin
      if (adj_pend_r) begin
        adj_pend_nxt = 1'b0;
      end else if (!delta_zero && (ent_type == ET_HIGH_ADJ) && !item.last_in_block) begin
        adj_pend_nxt = 1'b1;
        adj_addr_nxt = addr;
        adj_high_nxt = item.target_value[HALF_W-1:0];
        adj_inb_nxt  = fits_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_pend_r <= 1'b0;
    end else begin
      adj_pend_r <= adj_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adj_addr_r <= adj_addr_nxt;
    adj_high_r <= adj_high_nxt;
    adj_inb_r  <= adj_inb_nxt;
  end
endmodule

>>> sv/base_relocation_fixup.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Base relocation fixup
// Patches one base relocation entry per beat and reports the write to make.
// Path: an entry beat taken on the input is registered in the entry register,
// then in the result register, which offers its result beat on the output.
// Throughput: one entry per cycle while the output channel is not stalled.
// Reset: rst_n (synchronous, active low) empties both stages, drops any held
// high-adjust and clears the delta and image size registers to zero.
// -----------------------------------------------------------------------------
module base_relocation_fixup (
  input  logic       clk,
  input  logic       rst_n,
  brf_in_if.sink     in_chan,
  brf_out_if.source  out_chan,
  brf_cfg_if.sink    cfg_chan
);
  import brf_pkg::*;

  // The block is a two-register pipe. The entry register captures each input
  // beat. The fixup datapath works on that register and, together with the
  // held high-adjust, produces one result. The result register then offers it
  // on the output channel. The entry register moves on whenever the result
  // register is empty or is being drained in the same cycle. While a result
  // waits on a stalled output, a full entry register holds its beat and the
  // input is not ready until the output drains.

  brf_cfg_t    cfg;
  brf_item_t   ent_r, ent_nxt;
  logic        ent_vld_r, ent_vld_nxt;
  brf_result_t res_r, res_nxt;
  brf_result_t fix_res;
  logic        res_vld_r, res_vld_nxt;
  logic        in_take;
  logic        advance;

  brf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // The held high-adjust state updates only when an entry leaves the entry
  // register, so entries are consumed strictly in arrival order.
  brf_fixup u_fixup (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (ent_r),
    .advance (advance),
    .result  (fix_res)
  );

  assign advance       = ent_vld_r && (!res_vld_r || out_chan.ready);
  assign in_chan.ready = !ent_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    ent_nxt     = ent_r;
    ent_vld_nxt = ent_vld_r;
    if (in_take) begin
      ent_nxt.entry         = in_chan.entry;
      ent_nxt.page_rva      = in_chan.page_rva;
      ent_nxt.target_value  = in_chan.target_value;
      ent_nxt.last_in_block = in_chan.last_in_block;
      ent_vld_nxt           = 1'b1;
    end else if (advance) begin
      ent_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    if (advance) begin
      res_nxt     = fix_res;
      res_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      ent_vld_r <= ent_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    res_r <= res_nxt;
  end

  assign out_chan.valid       = res_vld_r;
  assign out_chan.write_kind  = res_r.write_kind;
  assign out_chan.target_addr = res_r.target_addr;
  assign out_chan.new_value   = res_r.new_value;
  assign out_chan.status      = res_r.status;
endmodule

>>> sv/brf_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Relocation fixup port checker
// Checks result beats seen on the top level ports.
// -----------------------------------------------------------------------------
module brf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_write_kind,
  input logic [brf_pkg::WORD_W-1:0] out_new_value,
  input logic [2:0]                out_status
);
  import brf_pkg::*;

  // A stalled result beat keeps its status and value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
                                   && $stable(out_new_value)))
    else $error("result beat changed while stalled");

  // A write happens exactly when the status says the patch was applied.
  a_write_iff_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_write_kind != WK_NONE) == (out_status == ST_APPLIED)))
    else $error("write kind disagrees with status");

  // Without a write the value is zero.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_write_kind == WK_NONE)) |-> (out_new_value == '0))
    else $error("value carried on a beat without a write");

  // Half-word writes leave the upper half clear.
  a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_write_kind == WK_HALF)) |-> (out_new_value[WORD_W-1:HALF_W] == '0))
    else $error("half-word write with upper bits set");
endmodule

bind base_relocation_fixup brf_checker u_brf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_write_kind (out_chan.write_kind),
  .out_new_value  (out_chan.new_value),
  .out_status     (out_chan.status)
);
